@@ hw/rtl/rct_pkg.sv @@
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types, constants and the standard genetic code table for the RNA
// codon translator.
// ----------------------------------------------------------------------------
package rct_pkg;

    // Base index of one kept character: U, C, A, G, or anything else.
    typedef logic [2:0] t_base;
    typedef logic [4:0] t_amino;

    localparam t_base BASE_U     = 3'd0;
    localparam t_base BASE_C     = 3'd1;
    localparam t_base BASE_A     = 3'd2;
    localparam t_base BASE_G     = 3'd3;
    localparam t_base BASE_OTHER = 3'd4;

    localparam t_amino AMINO_MET     = 5'd10;
    localparam t_amino AMINO_STOP    = 5'd20;
    localparam t_amino AMINO_UNKNOWN = 5'd21;

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LF      = 8'h0A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHAR_CASE    = 8'h20;
    localparam logic [7:0] CHAR_U       = 8'h55;
    localparam logic [7:0] CHAR_C       = 8'h43;
    localparam logic [7:0] CHAR_A       = 8'h41;
    localparam logic [7:0] CHAR_G       = 8'h47;

    // Indexed by {first, second, third} base with U=0, C=1, A=2, G=3.
    localparam t_amino GENETIC_CODE [64] = '{
        5'd4,  5'd4,  5'd9,  5'd9,  5'd15, 5'd15, 5'd15, 5'd15,
        5'd19, 5'd19, 5'd20, 5'd20, 5'd1,  5'd1,  5'd20, 5'd18,
        5'd9,  5'd9,  5'd9,  5'd9,  5'd12, 5'd12, 5'd12, 5'd12,
        5'd6,  5'd6,  5'd13, 5'd13, 5'd14, 5'd14, 5'd14, 5'd14,
        5'd7,  5'd7,  5'd7,  5'd10, 5'd16, 5'd16, 5'd16, 5'd16,
        5'd11, 5'd11, 5'd8,  5'd8,  5'd15, 5'd15, 5'd14, 5'd14,
        5'd17, 5'd17, 5'd17, 5'd17, 5'd0,  5'd0,  5'd0,  5'd0,
        5'd2,  5'd2,  5'd3,  5'd3,  5'd5,  5'd5,  5'd5,  5'd5
    };

    // Folds a lower-case letter and maps the character to its base index.
    function automatic t_base base_of(input logic [7:0] ch);
        logic [7:0] up;
        t_base      b;
        up = ch;
        if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
            up = ch - CHAR_CASE;
        end
        case (up)
            CHAR_U:  b = BASE_U;
            CHAR_C:  b = BASE_C;
            CHAR_A:  b = BASE_A;
            CHAR_G:  b = BASE_G;
            default: b = BASE_OTHER;
        endcase
        return b;
    endfunction

endpackage

@@ hw/rtl/rct_codon_lookup.sv @@
// ----------------------------------------------------------------------------
// rct_codon_lookup
// Maps three base indices to an amino-acid code through the standard
// genetic code; any base outside ACGU gives the unknown code.
// ----------------------------------------------------------------------------
module rct_codon_lookup
    import rct_pkg::*;
(
    input  t_base  i_base1,
    input  t_base  i_base2,
    input  t_base  i_base3,
    output t_amino o_code
);

    logic [5:0] codon_idx;

    assign codon_idx = {i_base1[1:0], i_base2[1:0], i_base3[1:0]};

    always_comb begin
        if (i_base1[2] || i_base2[2] || i_base3[2]) begin
            o_code = AMINO_UNKNOWN;
        end else begin
            o_code = GENETIC_CODE[codon_idx];
        end
    end

endmodule

@@ hw/rtl/rna_codon_translator_core.sv @@
// ----------------------------------------------------------------------------
// rna_codon_translator_core
// Translates an RNA character stream into amino-acid codes.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle and, when a character
// completes the start codon or a codon after it, presents the amino-acid code
// in the next cycle from an output register. The scan state and the table lookup
// are settled in the same cycle the character is accepted, so the next
// character is taken in the very next cycle; the input stalls only while a
// result sits in the output register and the downstream side is not ready.
// Space, CR and LF are dropped, letters are folded to upper case, and a set
// tuser bit clears the held count and the start and halt flags before its character is handled.
module rna_codon_translator_core
    import rct_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] symbol
    input  logic       i_s_tuser,   // [0] new_sequence
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [4:0] amino_code, [7:5] zero
);

    t_base      r_held1, r_held2, n_held1, n_held2;
    logic [1:0] r_count, n_count;
    logic       r_translating, n_translating;
    logic       r_halted, n_halted;
    logic       r_out_valid;
    t_amino     r_out_code;

    logic       s_accept;
    logic       dropped;
    t_base      sym_base;
    t_amino     lut_code;
    logic       emit;
    t_amino     emit_code;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign dropped    = (i_s_tdata == CHAR_SPACE) || (i_s_tdata == CHAR_CR) ||
                        (i_s_tdata == CHAR_LF);
    assign sym_base   = base_of(i_s_tdata);

    rct_codon_lookup u_lookup (
        .i_base1 (n_held1),
        .i_base2 (n_held2),
        .i_base3 (sym_base),
        .o_code  (lut_code)
    );

    // The held bases feeding the lookup are the state after an optional
    // sequence clear; a cleared count keeps the lookup result unused.
    always_comb begin
        n_held1       = r_held1;
        n_held2       = r_held2;
        n_count       = r_count;
        n_translating = r_translating;
        n_halted      = r_halted;
        if (i_s_tuser) begin
            n_count       = 2'd0;
            n_translating = 1'b0;
            n_halted      = 1'b0;
        end
    end

    logic [1:0] f_count;
    logic       f_translating, f_halted;
    t_base      f_held1, f_held2;

    always_comb begin
        f_held1       = n_held1;
        f_held2       = n_held2;
        f_count       = n_count;
        f_translating = n_translating;
        f_halted      = n_halted;
        emit          = 1'b0;
        emit_code     = lut_code;
        if (!dropped && !n_halted) begin
            if (!n_translating) begin
                if (n_count == 2'd2 && n_held1 == BASE_A && n_held2 == BASE_U &&
                    sym_base == BASE_G) begin
                    f_translating = 1'b1;
                    f_count       = 2'd0;
                    emit          = 1'b1;
                    emit_code     = AMINO_MET;
                end else begin
                    f_held1 = n_held2;
                    f_held2 = sym_base;
                    if (n_count != 2'd2) begin
                        f_count = n_count + 2'd1;
                    end
                end
            end else if (n_count == 2'd2) begin
                f_count = 2'd0;
                emit    = 1'b1;
                if (lut_code == AMINO_STOP) begin
                    f_halted = 1'b1;
                end
            end else begin
                f_held1 = n_held2;
                f_held2 = sym_base;
                f_count = n_count + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count       <= 2'd0;
            r_translating <= 1'b0;
            r_halted      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (s_accept) begin
                r_count       <= f_count;
                r_translating <= f_translating;
                r_halted      <= f_halted;
            end
            if (s_accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_held1 <= f_held1;
            r_held2 <= f_held2;
        end
        if (s_accept && emit) begin
            r_out_code <= emit_code;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_code};

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("held count out of range");

    a_halt_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |-> r_translating)
        else $error("halted without a start codon");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_code <= AMINO_UNKNOWN))
        else $error("amino code out of range");

    a_halt_on_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_halted) |-> (r_out_valid && r_out_code == AMINO_STOP))
        else $error("halt without a stop result");

    a_start_emits_met: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(r_translating) && !r_halted) |-> (r_out_valid && r_out_code == AMINO_MET))
        else $error("start codon without Met result");

endmodule
